FILE: sv/esl_pkg.sv
// Shared types, constants and the control program for the epoch to local date converter.
// Used by esl_seq, esl_dp and epoch_seconds_to_local_date_time; depends on nothing else.
`default_nettype none

package esl_pkg;

  localparam int EPOCH_W  = 32;
  localparam int OFFSET_W = 5;
  localparam int TIME_W   = 33;   // local seconds after the offset and clamp
  localparam int REM_W    = 17;   // seconds within the day
  localparam int DAYS_W   = 16;
  localparam int YEAR_W   = 12;
  localparam int PC_W     = 4;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR     = 12'd1970;
  localparam logic [6:0]        EPOCH_YEAR_100 = 7'd70;    // 1970 mod 100
  localparam logic [8:0]        EPOCH_YEAR_400 = 9'd370;   // 1970 mod 400
  localparam logic [6:0]        LAST_YEAR_100  = 7'd99;
  localparam logic [8:0]        LAST_YEAR_400  = 9'd399;
  localparam logic [3:0]        LAST_MONTH     = 4'd11;    // December, counted from 0

  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = -5'sd6;
  localparam logic signed [17:0]         SECS_PER_HOUR_S = 18'sd3600;

  localparam logic [REM_W-1:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [REM_W-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [11:0]      SECS_PER_MIN  = 12'd60;

  // Reciprocals for exact division of the shifted dividend by the odd part of each divisor:
  // 86400 = 675 * 2^7, 3600 = 225 * 2^4 and 60 = 15 * 2^2. Each is the ceiling of 2^k over
  // the odd part, with k large enough that the rounding error never reaches the next integer.
  localparam logic [26:0] DAY_RECIP  = 27'd101806633;   // 2^36 / 675
  localparam logic [13:0] HOUR_RECIP = 14'd9321;        // 2^21 / 225
  localparam logic [10:0] MIN_RECIP  = 11'd1093;        // 2^14 / 15

  // Datapath operations.
  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_QDAY  = 4'd2;
  localparam logic [3:0] OP_RDAY  = 4'd3;
  localparam logic [3:0] OP_QHOUR = 4'd4;
  localparam logic [3:0] OP_RHOUR = 4'd5;
  localparam logic [3:0] OP_QMIN  = 4'd6;
  localparam logic [3:0] OP_RMIN  = 4'd7;
  localparam logic [3:0] OP_YEAR  = 4'd8;
  localparam logic [3:0] OP_MONTH = 4'd9;
  localparam logic [3:0] OP_EMIT  = 4'd10;

  // Jump conditions: the step jumps to its target when the condition holds.
  localparam logic [2:0] COND_NONE     = 3'd0;
  localparam logic [2:0] COND_ALWAYS   = 3'd1;
  localparam logic [2:0] COND_NO_IN    = 3'd2;
  localparam logic [2:0] COND_YEAR     = 3'd3;
  localparam logic [2:0] COND_MONTH    = 3'd4;
  localparam logic [2:0] COND_OUT_BUSY = 3'd5;

  // Program addresses.
  localparam logic [PC_W-1:0] STEP_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] STEP_QDAY   = 4'd1;
  localparam logic [PC_W-1:0] STEP_RDAY   = 4'd2;
  localparam logic [PC_W-1:0] STEP_QHOUR  = 4'd3;
  localparam logic [PC_W-1:0] STEP_RHOUR  = 4'd4;
  localparam logic [PC_W-1:0] STEP_QMIN   = 4'd5;
  localparam logic [PC_W-1:0] STEP_RMIN   = 4'd6;
  localparam logic [PC_W-1:0] STEP_YEAR   = 4'd7;
  localparam logic [PC_W-1:0] STEP_MONTH  = 4'd8;
  localparam logic [PC_W-1:0] STEP_EMIT   = 4'd9;
  localparam logic [PC_W-1:0] STEP_RETURN = 4'd10;

  typedef struct packed {
    logic [3:0]      op;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic year_ge;
    logic month_ge;
  } status_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day_of_month;
    logic [3:0]        hour_12;
    logic              is_pm;
    logic [5:0]        minute;
    logic [5:0]        second;
  } result_t;

  function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      STEP_IDLE:   w = '{OP_LOAD,  COND_NO_IN,    STEP_IDLE};
      STEP_QDAY:   w = '{OP_QDAY,  COND_NONE,     STEP_IDLE};
      STEP_RDAY:   w = '{OP_RDAY,  COND_NONE,     STEP_IDLE};
      STEP_QHOUR:  w = '{OP_QHOUR, COND_NONE,     STEP_IDLE};
      STEP_RHOUR:  w = '{OP_RHOUR, COND_NONE,     STEP_IDLE};
      STEP_QMIN:   w = '{OP_QMIN,  COND_NONE,     STEP_IDLE};
      STEP_RMIN:   w = '{OP_RMIN,  COND_NONE,     STEP_IDLE};
      STEP_YEAR:   w = '{OP_YEAR,  COND_YEAR,     STEP_YEAR};
      STEP_MONTH:  w = '{OP_MONTH, COND_MONTH,    STEP_MONTH};
      STEP_EMIT:   w = '{OP_EMIT,  COND_OUT_BUSY, STEP_EMIT};
      STEP_RETURN: w = '{OP_NOP,   COND_ALWAYS,   STEP_IDLE};
      default:     w = '{OP_NOP,   COND_ALWAYS,   STEP_IDLE};
    endcase
    return w;
  endfunction

  // Month numbered from 0.
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd1:    n = leap ? 5'd29 : 5'd28;
      4'd3:    n = 5'd30;
      4'd5:    n = 5'd30;
      4'd8:    n = 5'd30;
      4'd10:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: sv/esl_seq.sv
// Sequencer: step counter and control program for the date converter.
// Depends on esl_pkg for the program table, the control word and the status group.
`default_nettype none

module esl_seq import esl_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire status_t st,
  output ctrl_t        cw
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            jump;

  assign cw = rom_word(pc);

  always_comb begin
    case (cw.cond)
      COND_NONE:     jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_IN:    jump = !st.in_valid;
      COND_YEAR:     jump = st.year_ge;
      COND_MONTH:    jump = st.month_ge;
      COND_OUT_BUSY: jump = st.out_busy;
      default:       jump = 1'b1;
    endcase
    pc_next = jump ? cw.target : pc + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/esl_dp.sv
// Datapath: offset and clamp, reciprocal divisions by the day, hour and minute lengths,
// and the year and month walk. Depends on esl_pkg; driven one control word per cycle by esl_seq.
`default_nettype none

module esl_dp import esl_pkg::*; (
  input  wire logic                       clk,
  input  wire ctrl_t                      cw,
  input  wire logic                       load,
  input  wire logic [EPOCH_W-1:0]         epoch_seconds,
  input  wire logic signed [OFFSET_W-1:0] offset_hours,
  output logic                            year_ge,
  output logic                            month_ge,
  output result_t                         res
);

  logic [TIME_W-1:0] t;
  logic [REM_W-1:0]  rem;
  logic [DAYS_W-1:0] days;
  logic [YEAR_W-1:0] year;
  logic [6:0]        year_100;
  logic [8:0]        year_400;
  logic [3:0]        month;
  logic [4:0]        h24;
  logic [5:0]        minute;
  logic [5:0]        second;

  logic signed [17:0] off_wide;
  logic signed [17:0] off_sec;
  logic [33:0]        t_raw;
  logic [TIME_W-1:0]  t_local;
  logic [52:0]        day_prod;
  logic [TIME_W-1:0]  day_secs;
  logic [TIME_W-1:0]  day_left;
  logic [26:0]        hour_prod;
  logic [REM_W-1:0]   hour_secs;
  logic [REM_W-1:0]   hour_left;
  logic [20:0]        min_prod;
  logic [11:0]        min_secs;
  logic [11:0]        sec_left;
  logic               leap;
  logic [8:0]         ylen;
  logic [4:0]         mlen;
  logic [4:0]         h_mod;

  // A local time before the epoch is clamped to midnight on the first day.
  always_comb begin
    off_wide = {{13{offset_hours[OFFSET_W-1]}}, offset_hours};
    off_sec  = off_wide * SECS_PER_HOUR_S;
    t_raw    = {2'b00, epoch_seconds} + {{16{off_sec[17]}}, off_sec};
    t_local  = t_raw[33] ? '0 : t_raw[TIME_W-1:0];
  end

  // Each quotient drops the power of two first, then multiplies by the reciprocal of the odd
  // part; the remainder is then taken from the registered quotient at the following step.
  always_comb begin
    day_prod  = 53'(t[TIME_W-1:7]) * 53'(DAY_RECIP);
    day_secs  = TIME_W'(days) * TIME_W'(SECS_PER_DAY);
    day_left  = t - day_secs;
    hour_prod = 27'(rem[REM_W-1:4]) * 27'(HOUR_RECIP);
    hour_secs = REM_W'(h24) * SECS_PER_HOUR;
    hour_left = rem - hour_secs;
    min_prod  = 21'(rem[11:2]) * 21'(MIN_RECIP);
    min_secs  = 12'(minute) * SECS_PER_MIN;
    sec_left  = rem[11:0] - min_secs;
  end

  always_comb begin
    leap     = (year[1:0] == 2'b00) && ((year_100 != 7'd0) || (year_400 == 9'd0));
    ylen     = leap ? 9'd366 : 9'd365;
    mlen     = month_days(month, leap);
    year_ge  = days >= {7'd0, ylen};
    month_ge = (month != LAST_MONTH) && (days >= {11'd0, mlen});
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      OP_LOAD: begin
        if (load) begin
          t <= t_local;
        end
      end
      OP_QDAY: begin
        days     <= day_prod[51:36];
        year     <= EPOCH_YEAR;
        year_100 <= EPOCH_YEAR_100;
        year_400 <= EPOCH_YEAR_400;
        month    <= 4'd0;
      end
      OP_RDAY: begin
        rem <= day_left[REM_W-1:0];
      end
      OP_QHOUR: begin
        h24 <= hour_prod[25:21];
      end
      OP_RHOUR: begin
        rem <= hour_left;
      end
      OP_QMIN: begin
        minute <= min_prod[19:14];
      end
      OP_RMIN: begin
        second <= sec_left[5:0];
      end
      OP_YEAR: begin
        if (year_ge) begin
          days     <= days - {7'd0, ylen};
          year     <= year + 12'd1;
          year_100 <= (year_100 == LAST_YEAR_100) ? 7'd0 : year_100 + 7'd1;
          year_400 <= (year_400 == LAST_YEAR_400) ? 9'd0 : year_400 + 9'd1;
        end
      end
      OP_MONTH: begin
        if (month_ge) begin
          days  <= days - {11'd0, mlen};
          month <= month + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    h_mod            = (h24 >= 5'd12) ? h24 - 5'd12 : h24;
    res.year         = year;
    res.month        = month + 4'd1;
    res.day_of_month = days[4:0] + 5'd1;
    res.hour_12      = (h_mod == 5'd0) ? 4'd12 : h_mod[3:0];
    res.is_pm        = h24 >= 5'd12;
    res.minute       = minute;
    res.second       = second;
  end

endmodule

`default_nettype wire

FILE: sv/epoch_seconds_to_local_date_time.sv
// Top level of the epoch seconds to local date and 12-hour time converter.
// Depends on esl_pkg, esl_seq and esl_dp; holds the offset register and the result register.
//
//   channel  direction  handshake              payload
//   in       request    in_valid / in_ready    epoch_seconds
//   cfg      write      cfg_valid / cfg_ready  utc_offset_hours
//   out      result     out_valid / out_ready  year .. second
//
// A request is taken only at the idle step, so the next waits until the last result is emitted.
// The time to a result grows with the whole years since 1970 and the months walked in the final
// year. Six steps split the time of day by reciprocal multiplication, and the calendar walk
// advances one year or one month per step.
// Reset returns the sequencer to idle, empties the result register and sets the offset to -6.
// A finished result waits in its own register, so a new request is taken while it is unread;
// the sequencer only holds at its emit step when the register is still full.
`default_nettype none

module epoch_seconds_to_local_date_time import esl_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [EPOCH_W-1:0]         epoch_seconds,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic signed [OFFSET_W-1:0] utc_offset_hours,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [YEAR_W-1:0]               year,
  output logic [3:0]                      month,
  output logic [4:0]                      day_of_month,
  output logic [3:0]                      hour_12,
  output logic                            is_pm,
  output logic [5:0]                      minute,
  output logic [5:0]                      second
);

  logic signed [OFFSET_W-1:0] offset_hours;
  ctrl_t   cw;
  status_t st;
  result_t res;
  logic    out_busy;
  logic    emit;
  logic    year_ge;
  logic    month_ge;

  assign cfg_ready = 1'b1;
  assign in_ready  = cw.op == OP_LOAD;
  assign out_busy  = out_valid && !out_ready;
  assign emit      = (cw.op == OP_EMIT) && !out_busy;

  assign st = '{in_valid: in_valid, out_busy: out_busy, year_ge: year_ge, month_ge: month_ge};

  esl_seq u_seq (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cw  (cw)
  );

  esl_dp u_dp (
    .clk           (clk),
    .cw            (cw),
    .load          (in_valid),
    .epoch_seconds (epoch_seconds),
    .offset_hours  (offset_hours),
    .year_ge       (year_ge),
    .month_ge      (month_ge),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_hours <= OFFSET_RESET;
    end else if (cfg_valid) begin
      offset_hours <= utc_offset_hours;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      year         <= res.year;
      month        <= res.month;
      day_of_month <= res.day_of_month;
      hour_12      <= res.hour_12;
      is_pm        <= res.is_pm;
      minute       <= res.minute;
      second       <= res.second;
    end
  end

endmodule

`default_nettype wire
